// ===== rtl/kmeans_lloyd_clustering_unit_defines.svh =====
// ----------------------------------------------------------------------------
// K-means clustering unit assertion macros
// Concurrent assertion helpers on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef KMEANS_LLOYD_CLUSTERING_UNIT_DEFINES_SVH
`define KMEANS_LLOYD_CLUSTERING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define KMLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmlc assertion failed");
`define KMLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmlc assertion failed");
`else
`define KMLC_ASSERT_SAME(lbl, ante, cons)
`define KMLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/kmlc_pkg.sv =====
// ----------------------------------------------------------------------------
// K-means clustering package
// Word types, codes and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package kmlc_pkg;

  localparam int COORD_W   = 32;
  localparam int SUM_W     = 48;
  localparam int DIST_W    = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_LOAD_POINT = 2'd0;
  localparam logic [1:0] OP_LOAD_CENT  = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;

  typedef struct packed {
    logic [1:0]                operation;
    logic [9:0]                entry_index;
    logic [2:0]                dim_index;
    logic signed [COORD_W-1:0] coord_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]                cluster_index;
    logic [2:0]                out_dim;
    logic signed [COORD_W-1:0] centroid_value;
    logic [15:0]               passes_done;
    logic                      last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_D_RD,
    ST_D_MUL,
    ST_D_ACC,
    ST_D_CMP,
    ST_S_RD,
    ST_S_WR,
    ST_U_RD,
    ST_U_DIV,
    ST_U_WAIT,
    ST_U_MUL,
    ST_U_ACC,
    ST_U_CMP,
    ST_E_RD,
    ST_E_LOAD
  } state_t;

  // |a - b| of two Q16.16 values always fits 32 unsigned bits
  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

endpackage

// ===== rtl/kmeans_lloyd_clustering_unit.sv =====
// ----------------------------------------------------------------------------
// K-means clustering unit
// Lloyd iterations over stored points with one shared squaring unit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  in_     | in  | in_valid / in_ready   | in_word_t: load point, load centroid, run
//  out_    | out | out_valid / out_ready | out_word_t: one centroid coordinate
//  cfg_    | in  | cfg_valid / cfg_ready | register index and write data
//
//  Loads are taken while idle. Per pass a run clears the whole sum store,
//  sums per point the squared distance to each centroid over the dims, adds
//  the point into the nearest centroid's sums, and per centroid divides each
//  sum by its member count (0 if empty), then the coordinates are emitted.
//  Reset is synchronous; stores are not cleared. in_ready drops for a run and
//  the emit sequence waits on out_ready.
// ----------------------------------------------------------------------------
`include "kmeans_lloyd_clustering_unit_defines.svh"

module kmeans_lloyd_clustering_unit
  import kmlc_pkg::*;
#(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_DIMS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
  localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int PAW    = PDEPTH > 1 ? $clog2(PDEPTH) : 1;
  localparam int CAW    = CDEPTH > 1 ? $clog2(CDEPTH) : 1;
  localparam int CIW    = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DIW    = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
  localparam int NW     = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;

  logic [3:0]  nc_r, nc_nxt;
  logic [3:0]  nd_r, nd_nxt;
  logic [10:0] np_r, np_nxt;
  logic [15:0] mi_r, mi_nxt;
  logic [31:0] thr_r, thr_nxt;

  logic [CIW-1:0]    last_c_r, last_c_nxt;
  logic [DIW-1:0]    last_j_r, last_j_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     i_r, i_nxt;
  logic [CIW-1:0]    c_r, c_nxt;
  logic [DIW-1:0]    j_r, j_nxt;
  logic [CIW-1:0]    best_r, best_nxt;
  logic [CAW-1:0]    clr_r, clr_nxt;
  logic [15:0]       pass_r, pass_nxt;
  logic              moved_r, moved_nxt;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [DIST_W-1:0] prod_r, prod_nxt;
  logic [COORD_W-1:0] old_r, old_nxt;
  logic [COORD_W-1:0] fresh_r, fresh_nxt;
  logic [NW-1:0]     cnt_r [MAX_CLUSTERS];
  logic [NW-1:0]     cnt_nxt [MAX_CLUSTERS];
  logic [NW-1:0]     cnt_cur;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  logic               p_we, c_we, s_we;
  logic [PAW-1:0]     p_wa, p_ra;
  logic [CAW-1:0]     c_wa, c_ra, s_wa, s_ra;
  logic [COORD_W-1:0] p_wd, c_wd, p_rd, c_rd;
  logic [SUM_W-1:0]   s_wd, s_rd;
  logic [COORD_W-1:0] mul_a;
  logic [DIST_W-1:0]  acc_sum;
  logic               in_acc;
  logic               div_start, div_busy, div_done;
  logic signed [COORD_W-1:0] div_q;
  logic [CAW-1:0]     cj_addr, bj_addr;

  kmlc_ram #(.W(COORD_W), .D(PDEPTH)) u_point_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
  );

  kmlc_ram #(.W(COORD_W), .D(CDEPTH)) u_cent_ram (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );

  kmlc_ram #(.W(SUM_W), .D(CDEPTH)) u_sum_ram (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );

  kmlc_div #(.DVW(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(s_rd), .divisor(cnt_cur),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nc_r        <= 4'd8;
      nd_r        <= 4'd8;
      np_r        <= 11'd1024;
      mi_r        <= 16'd200;
      thr_r       <= 32'd4295;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
      moved_r     <= 1'b0;
      for (int q = 0; q < MAX_CLUSTERS; q++) begin
        cnt_r[q] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      nc_r        <= nc_nxt;
      nd_r        <= nd_nxt;
      np_r        <= np_nxt;
      mi_r        <= mi_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      moved_r     <= moved_nxt;
      for (int q = 0; q < MAX_CLUSTERS; q++) begin
        cnt_r[q] <= cnt_nxt[q];
      end
    end
    last_c_r <= last_c_nxt;
    last_j_r <= last_j_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    c_r      <= c_nxt;
    j_r      <= j_nxt;
    best_r   <= best_nxt;
    clr_r    <= clr_nxt;
    acc_r    <= acc_nxt;
    best_d_r <= best_d_nxt;
    prod_r   <= prod_nxt;
    old_r    <= old_nxt;
    fresh_r  <= fresh_nxt;
    out_r    <= out_nxt;
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = state_r == ST_IDLE;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cj_addr = CAW'(int'(c_r) * MAX_DIMS + int'(j_r));
  assign bj_addr = CAW'(int'(best_r) * MAX_DIMS + int'(j_r));
  assign p_ra    = PAW'(int'(i_r) * MAX_DIMS + int'(j_r));
  assign c_ra    = cj_addr;
  assign s_ra    = (state_r == ST_S_RD || state_r == ST_S_WR) ? bj_addr : cj_addr;
  assign cnt_cur = (state_r == ST_S_WR) ? cnt_r[best_r] : cnt_r[c_r];

  assign mul_a   = (state_r == ST_D_MUL) ? abs_diff(p_rd, c_rd) : abs_diff(old_r, fresh_r);
  assign acc_sum = sat_add(acc_r, prod_r);

  always_comb begin
    state_nxt     = state_r;
    nc_nxt        = nc_r;
    nd_nxt        = nd_r;
    np_nxt        = np_r;
    mi_nxt        = mi_r;
    thr_nxt       = thr_r;
    last_c_nxt    = last_c_r;
    last_j_nxt    = last_j_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    c_nxt         = c_r;
    j_nxt         = j_r;
    best_nxt      = best_r;
    clr_nxt       = clr_r;
    pass_nxt      = pass_r;
    moved_nxt     = moved_r;
    acc_nxt       = acc_r;
    best_d_nxt    = best_d_r;
    prod_nxt      = {32'b0, mul_a} * {32'b0, mul_a};
    old_nxt       = old_r;
    fresh_nxt     = fresh_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int q = 0; q < MAX_CLUSTERS; q++) begin
      cnt_nxt[q] = cnt_r[q];
    end
    p_we      = 1'b0;
    p_wa      = PAW'(int'(in_data.entry_index) * MAX_DIMS + int'(in_data.dim_index));
    p_wd      = in_data.coord_value;
    c_we      = 1'b0;
    c_wa      = CAW'(int'(in_data.entry_index) * MAX_DIMS + int'(in_data.dim_index));
    c_wd      = in_data.coord_value;
    s_we      = 1'b0;
    s_wa      = clr_r;
    s_wd      = '0;
    div_start = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_CLUSTERS: nc_nxt  = cfg_data[3:0];
        REG_NUM_DIMS:     nd_nxt  = cfg_data[3:0];
        REG_NUM_POINTS:   np_nxt  = cfg_data[10:0];
        REG_MAX_ITER:     mi_nxt  = cfg_data[15:0];
        REG_THRESHOLD:    thr_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.operation == OP_LOAD_POINT) begin
            p_we = (int'(in_data.entry_index) < MAX_POINTS) &&
                   (int'(in_data.dim_index) < MAX_DIMS);
          end else if (in_data.operation == OP_LOAD_CENT) begin
            c_we = (int'(in_data.entry_index) < MAX_CLUSTERS) &&
                   (int'(in_data.dim_index) < MAX_DIMS);
          end else if (in_data.operation == OP_RUN) begin
            if (nc_r == 4'd0) begin
              last_c_nxt = '0;
            end else if (int'(nc_r) > MAX_CLUSTERS) begin
              last_c_nxt = CIW'(MAX_CLUSTERS - 1);
            end else begin
              last_c_nxt = CIW'(int'(nc_r) - 1);
            end
            if (nd_r == 4'd0) begin
              last_j_nxt = '0;
            end else if (int'(nd_r) > MAX_DIMS) begin
              last_j_nxt = DIW'(MAX_DIMS - 1);
            end else begin
              last_j_nxt = DIW'(int'(nd_r) - 1);
            end
            n_nxt    = (int'(np_r) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(np_r);
            pass_nxt = '0;
            c_nxt    = '0;
            j_nxt    = '0;
            clr_nxt  = '0;
            state_nxt = (mi_r == 16'd0) ? ST_E_RD : ST_CLR;
          end
        end
      end
      ST_CLR: begin
        s_we      = 1'b1;
        moved_nxt = 1'b0;
        for (int q = 0; q < MAX_CLUSTERS; q++) begin
          cnt_nxt[q] = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CAW'(CDEPTH - 1)) begin
          i_nxt   = '0;
          c_nxt   = '0;
          j_nxt   = '0;
          acc_nxt = '0;
          state_nxt = (n_r == '0) ? ST_U_RD : ST_D_RD;
        end
      end
      ST_D_RD: begin
        state_nxt = ST_D_MUL;
      end
      ST_D_MUL: begin
        state_nxt = ST_D_ACC;
      end
      ST_D_ACC: begin
        acc_nxt = acc_sum;
        if (j_r == last_j_r) begin
          state_nxt = ST_D_CMP;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_D_RD;
        end
      end
      ST_D_CMP: begin
        if (c_r == '0 || acc_r < best_d_r) begin
          best_d_nxt = acc_r;
          best_nxt   = c_r;
        end
        j_nxt   = '0;
        acc_nxt = '0;
        if (c_r == last_c_r) begin
          state_nxt = ST_S_RD;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = ST_D_RD;
        end
      end
      ST_S_RD: begin
        state_nxt = ST_S_WR;
      end
      ST_S_WR: begin
        s_we = 1'b1;
        s_wa = bj_addr;
        s_wd = s_rd + {{(SUM_W - COORD_W){p_rd[COORD_W-1]}}, p_rd};
        if (j_r == last_j_r) begin
          cnt_nxt[best_r] = cnt_cur + 1'b1;
          i_nxt   = i_r + 1'b1;
          c_nxt   = '0;
          j_nxt   = '0;
          acc_nxt = '0;
          state_nxt = (i_r + 1'b1 == n_r) ? ST_U_RD : ST_D_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_S_RD;
        end
      end
      ST_U_RD: begin
        state_nxt = ST_U_DIV;
      end
      ST_U_DIV: begin
        old_nxt = c_rd;
        if (cnt_cur == '0) begin
          fresh_nxt = '0;
          state_nxt = ST_U_MUL;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_U_WAIT;
        end
      end
      ST_U_WAIT: begin
        if (div_done) begin
          fresh_nxt = div_q;
          state_nxt = ST_U_MUL;
        end
      end
      ST_U_MUL: begin
        c_we = 1'b1;
        c_wa = cj_addr;
        c_wd = fresh_r;
        state_nxt = ST_U_ACC;
      end
      ST_U_ACC: begin
        acc_nxt = acc_sum;
        if (j_r == last_j_r) begin
          state_nxt = ST_U_CMP;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_U_RD;
        end
      end
      ST_U_CMP: begin
        moved_nxt = moved_r || (acc_r > {32'b0, thr_r});
        j_nxt     = '0;
        acc_nxt   = '0;
        if (c_r == last_c_r) begin
          c_nxt    = '0;
          clr_nxt  = '0;
          pass_nxt = pass_r + 1'b1;
          state_nxt = (moved_nxt && (pass_r + 1'b1 < mi_r)) ? ST_CLR : ST_E_RD;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = ST_U_RD;
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_LOAD;
      end
      ST_E_LOAD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.cluster_index = 3'(c_r);
          out_nxt.out_dim       = 3'(j_r);
          out_nxt.centroid_value = c_rd;
          out_nxt.passes_done   = pass_r;
          out_nxt.last          = (c_r == last_c_r) && (j_r == last_j_r);
          if (j_r == last_j_r) begin
            j_nxt = '0;
            if (c_r == last_c_r) begin
              state_nxt = ST_IDLE;
            end else begin
              c_nxt     = c_r + 1'b1;
              state_nxt = ST_E_RD;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_E_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `KMLC_ASSERT_NEXT(a_run_leaves_idle, in_acc && in_data.operation == OP_RUN, state_r != ST_IDLE)
  `KMLC_ASSERT_SAME(a_wait_has_div, state_r == ST_U_WAIT, div_busy || div_done)
  `KMLC_ASSERT_SAME(a_best_in_range, state_r == ST_S_WR, best_r <= last_c_r)
  `KMLC_ASSERT_NEXT(a_emit_fills_out, state_r == ST_E_LOAD && !out_valid_r, out_valid_r)

endmodule

// ===== rtl/kmlc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kmlc_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  raddr,
  output logic [W-1:0]                        rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kmlc_div.sv =====
// ----------------------------------------------------------------------------
// Member mean divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module kmlc_div
  import kmlc_pkg::*;
#(
  parameter int DVW = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   dividend,
  input  logic [DVW-1:0]            divisor,
  output logic                      busy,
  output logic                      done,
  output logic signed [COORD_W-1:0] quotient
);

  localparam int STW = $clog2(SUM_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STW-1:0]      step_r, step_nxt;
  logic [DVW-1:0]      rem_r, rem_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [DVW-1:0]      dvs_r, dvs_nxt;
  logic                neg_r, neg_nxt;
  logic [COORD_W-1:0]  q_r, q_nxt;
  logic [DVW:0]        rem_sh;
  logic                qbit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    qbit     = rem_sh >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      neg_nxt  = dividend[SUM_W-1];
      quo_nxt  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = qbit ? DVW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVW-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], qbit};
      step_nxt = step_r + 1'b1;
      if (step_r == STW'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        q_nxt    = neg_r ? (~quo_nxt[COORD_W-1:0] + 1'b1) : quo_nxt[COORD_W-1:0];
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule
